// ===== rtl/jddm_pkg.sv =====
// ----------------------------------------------------------------------------
// jddm_pkg
// Types, constants and the arctangent table for the differential drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

  // CORDIC micro-rotations per sample (8..24)
  localparam int CORDIC_STEPS  = 16;
  // top of the duty map input range (64..256)
  localparam int MAP_INPUT_TOP = 128;

  localparam int ATAN_LEN    = 24;
  localparam int ATAN_IDX_W  = $clog2(ATAN_LEN);
  // step counter must also hold the isqrt and divider step counts
  localparam int STEP_W      = $clog2(CORDIC_STEPS + 1);
  localparam int ISQRT_STEPS = 8;
  localparam int DIV_STEPS   = 8;

  // CORDIC vector width: 8-bit stick scaled by 2^16, times gain, plus sign
  localparam int CW = 27;
  // angle accumulator width, binary angle units
  localparam int ZW = 18;
  // speed width, Q8 signed
  localparam int SPW = 20;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;

  localparam logic [6:0] DEAD_ZONE_RST = 7'd16;
  localparam logic [7:0] MAX_SPEED_RST = 8'd100;

  localparam logic signed [ZW-1:0] ANG_QUARTER = 18'sd16384;
  localparam logic signed [ZW-1:0] ANG_HALF    = 18'sd32768;
  localparam logic signed [ZW-1:0] ANG_TURN    = 18'sd65536;

  typedef struct packed {
    logic signed [7:0] joy_x;
    logic signed [7:0] joy_y;
  } mix_in_t;

  typedef struct packed {
    logic       left_brake;
    logic       left_forward;
    logic [7:0] left_duty;
    logic       right_brake;
    logic       right_forward;
    logic [7:0] right_duty;
  } mix_out_t;

  typedef struct packed {
    logic       brake;
    logic       forward;
    logic [7:0] duty;
  } drive_t;

  // atan(2^-i) in binary angle units, 65536 per turn
  function automatic logic [13:0] atan_unit(input logic [ATAN_IDX_W-1:0] idx);
    logic [13:0] val;
    case (idx)
      5'd0:    val = 14'd8192;
      5'd1:    val = 14'd4836;
      5'd2:    val = 14'd2555;
      5'd3:    val = 14'd1297;
      5'd4:    val = 14'd651;
      5'd5:    val = 14'd326;
      5'd6:    val = 14'd163;
      5'd7:    val = 14'd81;
      5'd8:    val = 14'd41;
      5'd9:    val = 14'd20;
      5'd10:   val = 14'd10;
      5'd11:   val = 14'd5;
      5'd12:   val = 14'd3;
      5'd13:   val = 14'd1;
      5'd14:   val = 14'd1;
      default: val = 14'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/joystick_differential_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Joystick sample to left/right motor brake, direction and duty (tank mix).
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    in_data_i  (jddm_pkg::mix_in_t)
//   out       output     out_valid_o / out_ready_i  out_data_o (jddm_pkg::mix_out_t)
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A sample in the stick dead zone goes from acceptance straight to the done state.
// Otherwise: the square states, CORDIC_STEPS CORDIC steps (the integer square
// root runs alongside), the mix states, then per motor the shared multiplier and,
// where needed, a range check and the 8-step restoring divider, then the output.
// One sample in flight; in_ready_o is high only when the sequencer is idle.
// A result waits in the output register, which does not stall the next sample
// until that sample finishes. No clearing pass after reset; cfg is always ready.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  jddm_pkg::mix_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output jddm_pkg::mix_out_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jddm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [7:0]                          cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_CORDIC,
    S_VA,
    S_MIX,
    S_MOT_MUL,
    S_MOT_CHK,
    S_MOT_DIV,
    S_DONE
  } state_e;

  localparam int CW  = jddm_pkg::CW;
  localparam int ZW  = jddm_pkg::ZW;
  localparam int SPW = jddm_pkg::SPW;
  localparam int SW  = jddm_pkg::STEP_W;

  state_e                state_q;
  logic [SW-1:0]         cnt_q;
  logic                  mot_q;
  logic [6:0]            dz_q;
  logic [7:0]            ms_q;
  jddm_pkg::drive_t      hold_q [2];
  logic                  out_valid_q;
  jddm_pkg::mix_out_t    out_q;

  logic signed [7:0]     x_q, y_q;
  logic [15:0]           sq_q;
  logic [15:0]           s_q, root_q, bit_q;
  logic signed [CW-1:0]  a_q, b_q;
  logic signed [ZW-1:0]  z_q;
  logic                  axis_q;
  logic signed [SPW-1:0] va_q;
  logic [1:0]            quad_q;
  logic signed [SPW-1:0] spd_q [2];
  logic [15:0]           dvd_q;
  logic [16:0]           dvs_q;
  logic [7:0]            quo_q;

  // ---------------- input side ----------------
  logic signed [7:0]    in_x, in_y;
  logic [7:0]           ax, ay;
  logic                 stick_active;
  logic signed [CW-1:0] a0, b0, a_init, b_init;
  logic signed [ZW-1:0] z_init;
  logic                 axis_init;

  always_comb begin
    in_x = in_data_i.joy_x;
    in_y = in_data_i.joy_y;
    ax   = in_x[7] ? 8'(-in_x) : 8'(in_x);
    ay   = in_y[7] ? 8'(-in_y) : 8'(in_y);
    stick_active = (ax >= {1'b0, dz_q}) || (ay >= {1'b0, dz_q});
    a0 = {{(CW-24){in_y[7]}}, in_y, 16'h0000};
    b0 = {{(CW-24){in_x[7]}}, in_x, 16'h0000};
    a_init = a0;
    b_init = b0;
    z_init = '0;
    if (in_y[7]) begin
      // quarter-turn pre-rotation into the upper half plane
      if (!in_x[7]) begin
        a_init = b0;
        b_init = -a0;
        z_init = jddm_pkg::ANG_QUARTER;
      end else begin
        a_init = -b0;
        b_init = a0;
        z_init = -jddm_pkg::ANG_QUARTER;
      end
    end
    axis_init = (in_x == 8'sd0) || (in_y == 8'sd0);
    if (in_x == 8'sd0) begin
      z_init = in_y[7] ? jddm_pkg::ANG_HALF : '0;
    end else if (in_y == 8'sd0) begin
      z_init = in_x[7] ? -jddm_pkg::ANG_QUARTER : jddm_pkg::ANG_QUARTER;
    end
  end

  // ---------------- CORDIC and isqrt step ----------------
  logic signed [CW-1:0] sh_a, sh_b, a_d, b_d;
  logic signed [ZW-1:0] atan_v, z_d;
  logic [16:0]          trial;
  logic [15:0]          s_d, root_d;

  always_comb begin
    sh_a   = a_q >>> cnt_q;
    sh_b   = b_q >>> cnt_q;
    atan_v = $signed({{(ZW-14){1'b0}},
                      jddm_pkg::atan_unit(jddm_pkg::ATAN_IDX_W'(cnt_q))});
    if (!b_q[CW-1]) begin
      a_d = a_q + sh_b;
      b_d = b_q - sh_a;
      z_d = z_q + atan_v;
    end else begin
      a_d = a_q - sh_b;
      b_d = b_q + sh_a;
      z_d = z_q - atan_v;
    end
    trial = {1'b0, root_q} + {1'b0, bit_q};
    if ({1'b0, s_q} >= trial) begin
      s_d    = s_q - trial[15:0];
      root_d = (root_q >> 1) + bit_q;
    end else begin
      s_d    = s_q;
      root_d = root_q >> 1;
    end
  end

  // ---------------- angle, quadrant ----------------
  logic signed [ZW-1:0] th;
  logic [13:0]          rem;
  logic [1:0]           quad;

  always_comb begin
    th = z_q;
    if (z_q > jddm_pkg::ANG_HALF) begin
      th = z_q - jddm_pkg::ANG_TURN;
    end else if (z_q <= -jddm_pkg::ANG_HALF) begin
      th = z_q + jddm_pkg::ANG_TURN;
    end
    rem = th[13:0];
    if (th < -jddm_pkg::ANG_QUARTER) begin
      quad = 2'd0;
    end else if (th < 0) begin
      quad = 2'd1;
    end else if (th < jddm_pkg::ANG_QUARTER) begin
      quad = 2'd2;
    end else begin
      quad = 2'd3;
    end
  end

  // ---------------- shared multiplier ----------------
  logic signed [8:0]  mul_a;
  logic signed [15:0] mul_b;
  logic signed [24:0] prod;

  logic signed [SPW-1:0] spd, mag, thr;
  logic [7:0]            diff;
  logic signed [9:0]     den;
  logic                  den_pos;
  logic [8:0]            den9;

  always_comb begin
    spd  = spd_q[mot_q];
    mag  = spd[SPW-1] ? -spd : spd;
    thr  = $signed({{(SPW-15){1'b0}}, dz_q, 8'h00});
    diff = mag[15:8] - {1'b0, dz_q};
    den  = 10'(jddm_pkg::MAP_INPUT_TOP) - $signed({3'b000, dz_q});
    den_pos = !den[9] && (den != 10'sd0);
    den9 = den[8:0];
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQX: begin
        mul_a = {x_q[7], x_q};
        mul_b = {{8{x_q[7]}}, x_q};
      end
      S_SQY: begin
        mul_a = {y_q[7], y_q};
        mul_b = {{8{y_q[7]}}, y_q};
      end
      S_VA: begin
        mul_a = {1'b0, root_q[7:0]};
        mul_b = 16'sd8192 - $signed({2'b00, rem});
      end
      S_MOT_MUL: begin
        mul_a = {1'b0, diff};
        mul_b = {8'h00, ms_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // ---------------- mix ----------------
  logic signed [SPW-1:0] two, vb, sum_p, sum_m, cap, ls, rs;

  always_comb begin
    two   = $signed({{(SPW-17){1'b0}}, root_q[7:0], 9'h000});
    cap   = $signed({{(SPW-16){1'b0}}, ms_q, 8'h00});
    sum_p = two + va_q;
    sum_m = two - va_q;
    vb    = cap;
    if (sum_p < vb) vb = sum_p;
    if (sum_m < vb) vb = sum_m;
    case (quad_q)
      2'd0: begin
        ls = -vb;
        rs = -va_q;
      end
      2'd1: begin
        ls = -va_q;
        rs = vb;
      end
      2'd2: begin
        ls = vb;
        rs = va_q;
      end
      default: begin
        ls = va_q;
        rs = -vb;
      end
    endcase
  end

  // ---------------- divider step ----------------
  logic [15:0] dvd_d;
  logic [7:0]  quo_d;

  always_comb begin
    if ({1'b0, dvd_q} >= dvs_q) begin
      dvd_d = dvd_q - dvs_q[15:0];
      quo_d = {quo_q[6:0], 1'b1};
    end else begin
      dvd_d = dvd_q;
      quo_d = {quo_q[6:0], 1'b0};
    end
  end

  // result register loads when the sequencer finishes and the slot is free
  logic out_load;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mot_q       <= 1'b0;
      dz_q        <= jddm_pkg::DEAD_ZONE_RST;
      ms_q        <= jddm_pkg::MAX_SPEED_RST;
      hold_q[0]   <= '{brake: 1'b1, forward: 1'b0, duty: 8'h00};
      hold_q[1]   <= '{brake: 1'b1, forward: 1'b0, duty: 8'h00};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          jddm_pkg::CFG_DEAD_ZONE: dz_q <= cfg_data_i[6:0];
          jddm_pkg::CFG_MAX_SPEED: ms_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            x_q    <= in_x;
            y_q    <= in_y;
            a_q    <= a_init;
            b_q    <= b_init;
            z_q    <= z_init;
            axis_q <= axis_init;
            mot_q  <= 1'b0;
            if (stick_active) begin
              state_q <= S_SQX;
            end else begin
              hold_q[0].brake <= 1'b1;
              hold_q[0].duty  <= 8'h00;
              hold_q[1].brake <= 1'b1;
              hold_q[1].duty  <= 8'h00;
              state_q <= S_DONE;
            end
          end
        end
        S_SQX: begin
          sq_q    <= prod[15:0];
          state_q <= S_SQY;
        end
        S_SQY: begin
          s_q     <= sq_q + prod[15:0];
          root_q  <= '0;
          bit_q   <= 16'h4000;
          cnt_q   <= '0;
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!axis_q) begin
            a_q <= a_d;
            b_q <= b_d;
            z_q <= z_d;
          end
          if (cnt_q < SW'(jddm_pkg::ISQRT_STEPS)) begin
            s_q    <= s_d;
            root_q <= root_d;
            bit_q  <= bit_q >> 2;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SW'(jddm_pkg::CORDIC_STEPS - 1)) begin
            state_q <= S_VA;
          end
        end
        S_VA: begin
          va_q    <= SPW'(prod >>> 5);
          quad_q  <= quad;
          state_q <= S_MIX;
        end
        S_MIX: begin
          spd_q[0] <= ls;
          spd_q[1] <= rs;
          state_q  <= S_MOT_MUL;
        end
        S_MOT_MUL: begin
          if (mag < thr) begin
            // below the motor dead zone: keep previous drive
            mot_q   <= 1'b1;
            state_q <= mot_q ? S_DONE : S_MOT_MUL;
          end else begin
            hold_q[mot_q].brake   <= 1'b0;
            hold_q[mot_q].forward <= !spd[SPW-1] && (spd != '0);
            if (!den_pos) begin
              hold_q[mot_q].duty <= ms_q;
              mot_q   <= 1'b1;
              state_q <= mot_q ? S_DONE : S_MOT_MUL;
            end else begin
              dvd_q   <= prod[15:0];
              state_q <= S_MOT_CHK;
            end
          end
        end
        S_MOT_CHK: begin
          // quotient above 255 saturates, else 8 quotient bits suffice
          if ({1'b0, dvd_q} >= {den9, 8'h00}) begin
            hold_q[mot_q].duty <= 8'hFF;
            mot_q   <= 1'b1;
            state_q <= mot_q ? S_DONE : S_MOT_MUL;
          end else begin
            dvs_q   <= {1'b0, den9, 7'h00};
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_MOT_DIV;
          end
        end
        S_MOT_DIV: begin
          dvd_q <= dvd_d;
          dvs_q <= dvs_q >> 1;
          quo_q <= quo_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SW'(jddm_pkg::DIV_STEPS - 1)) begin
            hold_q[mot_q].duty <= quo_d;
            mot_q   <= 1'b1;
            state_q <= mot_q ? S_DONE : S_MOT_MUL;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_q.left_brake    <= hold_q[0].brake;
            out_q.left_forward  <= hold_q[0].forward;
            out_q.left_duty     <= hold_q[0].duty;
            out_q.right_brake   <= hold_q[1].brake;
            out_q.right_forward <= hold_q[1].forward;
            out_q.right_duty    <= hold_q[1].duty;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // ---------------- assertions ----------------
  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared without finishing a transaction");

  a_brake_zero_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!hold_q[0].brake || hold_q[0].duty == 8'h00) &&
    (!hold_q[1].brake || hold_q[1].duty == 8'h00))
    else $error("motor braked with nonzero duty");

  a_div_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOT_DIV |-> {2'b00, dvd_q} < {dvs_q, 1'b0})
    else $error("divider remainder out of range");

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted transaction not started");

endmodule

// ===== tb/tb_joystick_differential_drive_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_differential_drive_mixer
// Self-checking bench for the tank drive mixer. A fixed table of stick samples
// (axes, corners, dead zone edges) runs first, then random samples across a
// series of dead_zone / max_speed settings. Every sample is mixed by an
// in-bench model (integer root, CORDIC angle, quadrant mix, duty map, held
// motor state) and each result is compared field by field, in order.
// Both channels stall at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_joystick_differential_drive_mixer;

  localparam int LIMIT_CYCLES    = 1000000;
  localparam int DRAIN_CYCLES    = 48;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 191;
  localparam int BURST_LEN       = 40;
  localparam int ROT_STEPS       = (jddm_pkg::CORDIC_STEPS < 24) ? jddm_pkg::CORDIC_STEPS : 24;

  // register indexes beyond the map; writes there must be dropped
  localparam logic [jddm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [jddm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // atan(2^-i), 65536 units per turn
  localparam int ATAN_BAM [24] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [7:0]  x;
    logic signed [7:0]  y;
    logic               has_want;
    jddm_pkg::mix_out_t want;
  } probe_t;

  localparam jddm_pkg::mix_out_t BRAKED_REV = '{1'b1, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0};
  localparam jddm_pkg::mix_out_t BRAKED_FWD = '{1'b1, 1'b1, 8'd0, 1'b1, 1'b1, 8'd0};
  localparam jddm_pkg::mix_out_t NO_WANT    = '0;

  localparam int NUM_PROBES = 25;
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{0, 0, 1'b1, BRAKED_REV},        // centered stick straight out of reset
    '{0, 127, 1'b0, NO_WANT},
    '{0, 0, 1'b1, BRAKED_FWD},        // dead zone keeps direction bits
    '{0, -128, 1'b0, NO_WANT},        // straight back: half turn
    '{127, 0, 1'b0, NO_WANT},
    '{-128, 0, 1'b0, NO_WANT},
    '{-128, -128, 1'b0, NO_WANT},
    '{127, 127, 1'b0, NO_WANT},
    '{-128, 127, 1'b0, NO_WANT},
    '{127, -128, 1'b0, NO_WANT},
    '{15, -15, 1'b0, NO_WANT},        // just inside dead zone
    '{16, 0, 1'b0, NO_WANT},          // on the dead zone edge
    '{-16, 0, 1'b0, NO_WANT},
    '{0, -16, 1'b0, NO_WANT},
    '{20, 20, 1'b0, NO_WANT},         // diagonal: right motor speed is zero, holds
    '{10, 15, 1'b0, NO_WANT},
    '{100, -3, 1'b0, NO_WANT},
    '{-3, 100, 1'b0, NO_WANT},
    '{-90, -90, 1'b0, NO_WANT},
    '{5, -120, 1'b0, NO_WANT},
    '{-120, 5, 1'b0, NO_WANT},
    '{1, 127, 1'b0, NO_WANT},
    '{-1, -128, 1'b0, NO_WANT},
    '{127, 1, 1'b0, NO_WANT},
    '{-127, -1, 1'b0, NO_WANT}
  };

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  jddm_pkg::mix_in_t                  in_data = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  jddm_pkg::mix_out_t                 out_data;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [jddm_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [7:0]                         cfg_data = '0;

  // model state
  int                 dead_zone_now = int'(jddm_pkg::DEAD_ZONE_RST);
  int                 max_speed_now = int'(jddm_pkg::MAX_SPEED_RST);
  jddm_pkg::drive_t   left_drive = '{1'b1, 1'b0, 8'd0};
  jddm_pkg::drive_t   right_drive = '{1'b1, 1'b0, 8'd0};
  jddm_pkg::mix_out_t pending_drives [$];

  int err_count = 0;
  int cycles = 0;
  int sent_count = 0;
  int in_gap_max = 16;
  int out_gap_max = 16;

  joystick_differential_drive_mixer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_joystick_differential_drive_mixer failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic int floor_root(int s);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  // angle from +y toward +x
  function automatic int stick_angle(int x, int y);
    longint a, b, na, nb;
    int z;
    z = 0;
    if (x == 0) return (y >= 0) ? 0 : 32768;
    if (y == 0) return (x > 0) ? 16384 : -16384;
    a = longint'(y) * 65536;
    b = longint'(x) * 65536;
    if (a < 0) begin
      if (b >= 0) begin
        na = b;  nb = -a; z = 16384;
      end else begin
        na = -b; nb = a;  z = -16384;
      end
      a = na;
      b = nb;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (b >= 0) begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        z += ATAN_BAM[i];
      end else begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        z -= ATAN_BAM[i];
      end
      a = na;
      b = nb;
    end
    if (z > 32768) z -= 65536;
    if (z <= -32768) z += 65536;
    return z;
  endfunction

  function automatic jddm_pkg::drive_t next_drive(jddm_pkg::drive_t m, int spd);
    int mag, ip, span, duty;
    jddm_pkg::drive_t n;
    mag = (spd < 0) ? -spd : spd;
    if (mag < dead_zone_now * 256) return m;
    n.brake   = 1'b0;
    n.forward = (spd > 0);
    ip   = mag >> 8;
    span = jddm_pkg::MAP_INPUT_TOP - dead_zone_now;
    if (span <= 0) duty = max_speed_now;
    else duty = ((ip - dead_zone_now) * max_speed_now) / span;
    n.duty = (duty > 255) ? 8'd255 : duty[7:0];
    return n;
  endfunction

  function automatic jddm_pkg::mix_out_t mix_stick(jddm_pkg::mix_in_t s);
    int x, y, r, th, rem, va, vb, two, ls, rs;
    jddm_pkg::mix_out_t o;
    x = int'(s.joy_x);
    y = int'(s.joy_y);
    if ((x < 0 ? -x : x) >= dead_zone_now || (y < 0 ? -y : y) >= dead_zone_now) begin
      r   = floor_root(x * x + y * y);
      th  = stick_angle(x, y);
      rem = (th + 65536) & 16383;
      va  = int'((longint'(r) * (8192 - rem)) >>> 5);
      vb  = max_speed_now * 256;
      two = r * 512;
      if (two + va < vb) vb = two + va;
      if (two - va < vb) vb = two - va;
      if (th < -16384) begin
        ls = -vb; rs = -va;
      end else if (th < 0) begin
        ls = -va; rs = vb;
      end else if (th < 16384) begin
        ls = vb;  rs = va;
      end else begin
        ls = va;  rs = -vb;
      end
      left_drive  = next_drive(left_drive, ls);
      right_drive = next_drive(right_drive, rs);
    end else begin
      left_drive.brake  = 1'b1;
      left_drive.duty   = 8'd0;
      right_drive.brake = 1'b1;
      right_drive.duty  = 8'd0;
    end
    o = '{left_drive.brake, left_drive.forward, left_drive.duty,
          right_drive.brake, right_drive.forward, right_drive.duty};
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int near_axis(int lim);
    int v;
    v = int'($urandom_range(0, 2 * lim)) - lim;
    return (v > 127) ? 127 : v;
  endfunction

  function automatic jddm_pkg::mix_in_t draw_sample();
    int pick;
    int corner [5];
    jddm_pkg::mix_in_t s;
    corner = '{-128, -1, 0, 1, 127};
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      s.joy_x = 8'(near_axis(dead_zone_now + 1));
      s.joy_y = 8'(near_axis(dead_zone_now + 1));
    end else if (pick == 2) begin
      s.joy_x = 8'(corner[$urandom_range(0, 4)]);
      s.joy_y = 8'(corner[$urandom_range(0, 4)]);
    end else begin
      s = 16'($urandom);
    end
    return s;
  endfunction

  task automatic send_sample(input jddm_pkg::mix_in_t s, input logic has_want,
                             input jddm_pkg::mix_out_t want);
    int gap;
    jddm_pkg::mix_out_t pred;
    if (sent_count % BURST_LEN == 0) in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk_i); while (!in_ready);
    sent_count++;
    pred = mix_stick(s);
    pending_drives.push_back(has_want ? want : pred);
  endtask

  // block idle: all results back, sequencer drained
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input int phase);
    logic [7:0]                     dz_val, ms_val;
    logic [jddm_pkg::CFG_IDX_W-1:0] idx [4];
    logic [7:0]                     val [4];
    case (phase)
      0: begin dz_val = 8'h00; ms_val = 8'h00; end
      1: begin dz_val = 8'h7F; ms_val = 8'hFF; end
      2: begin dz_val = 8'h00; ms_val = 8'hFF; end
      3: begin dz_val = 8'hFF; ms_val = 8'h00; end  // top bit dropped by the 7-bit field
      default: begin
        dz_val = 8'($urandom_range(0, 255));
        ms_val = 8'($urandom_range(0, 255));
      end
    endcase
    idx = '{REG_SPARE_LO, jddm_pkg::CFG_DEAD_ZONE, REG_SPARE_HI, jddm_pkg::CFG_MAX_SPEED};
    val = '{8'($urandom), dz_val, 8'($urandom), ms_val};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk_i); while (!cfg_ready);
      case (idx[k])
        jddm_pkg::CFG_DEAD_ZONE: dead_zone_now = int'(val[k][6:0]);
        jddm_pkg::CFG_MAX_SPEED: max_speed_now = int'(val[k]);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int k = 0; k < NUM_PROBES; k++)
      send_sample({PROBES[k].x, PROBES[k].y}, PROBES[k].has_want, PROBES[k].want);
    settle();
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_regs(p);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_sample(draw_sample(), 1'b0, NO_WANT);
      settle();
    end
    if (err_count == 0) begin
      $display("tb_joystick_differential_drive_mixer passed");
    end else begin
      $display("tb_joystick_differential_drive_mixer failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  initial begin
    int gap, seen;
    jddm_pkg::mix_out_t want;
    seen = 0;
    wait (rst_ni);
    forever begin
      if (seen % BURST_LEN == 0) out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      seen++;
      if (pending_drives.size() == 0) begin
        $error("drive result with no sample outstanding");
        err_count++;
      end else begin
        want = pending_drives.pop_front();
        check_field("left_brake", int'(want.left_brake), int'(out_data.left_brake));
        check_field("left_forward", int'(want.left_forward), int'(out_data.left_forward));
        check_field("left_duty", int'(want.left_duty), int'(out_data.left_duty));
        check_field("right_brake", int'(want.right_brake), int'(out_data.right_brake));
        check_field("right_forward", int'(want.right_forward),
                    int'(out_data.right_forward));
        check_field("right_duty", int'(want.right_duty), int'(out_data.right_duty));
      end
    end
  end

endmodule
